// ===== design/crc16lpfr_pkg.sv =====
package crc16lpfr_pkg;

    // Kind of one result word, carried on the master tuser.
    typedef enum logic [1:0] {
        KIND_PAYLOAD    = 2'd0,
        KIND_FRAME_DONE = 2'd1,
        KIND_LEN_ERR    = 2'd2
    } t_kind;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned CRC_W      = 16;
    localparam int unsigned OUT_DATA_W = 40;  // 33 bits of fields padded to whole bytes

    localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 16'd5;
    localparam logic [LEN_W:0]   CRC_BYTES     = 17'd2;
    localparam logic [CRC_W-1:0] CRC_POLY      = 16'h1021;

    // One byte of CRC-16/XMODEM, most significant bit first.
    function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== design/crc16_length_prefixed_frame_receiver_core.sv =====
// Length-prefixed frame receiver with CRC-16/XMODEM check. Received bytes enter one word
// at a time on the slave stream. A frame is a 16-bit big-endian total byte count (which
// counts the whole frame), one identifier byte, count-5 payload bytes and a CRC-16/XMODEM
// (polynomial 0x1021, initial value 0) sent high byte first, covering every byte before
// it. Each payload byte leaves on the master stream as soon as it arrives; the last CRC
// byte yields a frame-complete word with the identifier, the length and the CRC match
// flag. A count below 5 yields a length-error word when its second byte arrives, and the
// byte after it is taken as the start of a new frame. Count, identifier and first CRC byte
// give no output word. The block takes one byte per clock: the byte-wide CRC update and
// the position compare sit between the frame state registers and the output register,
// and a byte is accepted whenever the output register is empty or is being drained in
// the same cycle, so the rate is one byte per cycle with no added bubbles.
module crc16_length_prefixed_frame_receiver_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [7:0] rx_byte
    input  logic [crc16lpfr_pkg::BYTE_W-1:0]        s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // [7:0] data_byte, [15:8] frame_ident, [16] crc_ok, [32:17] total_length,
    // [39:33] zero
    output logic [crc16lpfr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [1:0] result_kind
    output logic [1:0]                              m_axis_tuser
);
    import crc16lpfr_pkg::*;

    // Frame state.
    logic [LEN_W-1:0]  r_pos,  n_pos;
    logic [LEN_W-1:0]  r_len,  n_len;
    logic [CRC_W-1:0]  r_crc,  n_crc;
    logic [BYTE_W-1:0] r_ident, n_ident;
    logic [BYTE_W-1:0] r_crc_hi, n_crc_hi;

    // Output register.
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    t_kind                 r_out_kind, n_out_kind;
    logic                  n_emit;

    logic                  w_accept;
    logic [LEN_W-1:0]      w_len_lo;
    logic [LEN_W:0]        w_pos_plus;
    logic [CRC_W-1:0]      w_crc_next;

    // A new byte can be taken while the held result is being drained.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_len_lo   = {r_len[LEN_W-1:BYTE_W], s_axis_tdata};
    assign w_pos_plus = {1'b0, r_pos} + CRC_BYTES;
    assign w_crc_next = crc_update(r_crc, s_axis_tdata);

    always_comb begin
        n_pos      = r_pos;
        n_len      = r_len;
        n_crc      = r_crc;
        n_ident    = r_ident;
        n_crc_hi   = r_crc_hi;
        n_emit     = 1'b0;
        n_out_kind = KIND_PAYLOAD;
        n_out_data = '0;
        priority if (r_pos == 16'd0) begin
            // High count byte opens the frame and restarts the CRC.
            n_len = {s_axis_tdata, 8'h00};
            n_crc = crc_update('0, s_axis_tdata);
            n_pos = 16'd1;
        end else if (r_pos == 16'd1) begin
            n_len = w_len_lo;
            if (w_len_lo < MIN_FRAME_LEN) begin
                // The count cannot hold header and CRC, so the frame is dropped.
                n_emit     = 1'b1;
                n_out_kind = KIND_LEN_ERR;
                n_out_data = {7'd0, w_len_lo, 1'b0, 8'h00, 8'h00};
                n_pos      = '0;
                n_crc      = '0;
            end else begin
                n_crc = w_crc_next;
                n_pos = 16'd2;
            end
        end else if (r_pos == 16'd2) begin
            n_ident = s_axis_tdata;
            n_crc   = w_crc_next;
            n_pos   = 16'd3;
        end else if (w_pos_plus < {1'b0, r_len}) begin
            // Payload byte goes straight out.
            n_crc      = w_crc_next;
            n_pos      = r_pos + 16'd1;
            n_emit     = 1'b1;
            n_out_kind = KIND_PAYLOAD;
            n_out_data = {7'd0, r_len, 1'b0, r_ident, s_axis_tdata};
        end else if (w_pos_plus == {1'b0, r_len}) begin
            n_crc_hi = s_axis_tdata;
            n_pos    = r_pos + 16'd1;
        end else begin
            // Last CRC byte closes the frame.
            n_emit     = 1'b1;
            n_out_kind = KIND_FRAME_DONE;
            n_out_data = {7'd0, r_len, ({r_crc_hi, s_axis_tdata} == r_crc), r_ident, 8'h00};
            n_pos      = '0;
            n_crc      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_len       <= '0;
            r_crc       <= '0;
            r_ident     <= '0;
            r_crc_hi    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_pos       <= n_pos;
                r_len       <= n_len;
                r_crc       <= n_crc;
                r_ident     <= n_ident;
                r_crc_hi    <= n_crc_hi;
                r_out_valid <= n_emit;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is only looked at while valid.
    always_ff @(posedge i_clk) begin
        if (w_accept && n_emit) begin
            r_out_data <= n_out_data;
            r_out_kind <= n_out_kind;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;

endmodule

// ===== design/crc16lpfr_checker.sv =====
module crc16lpfr_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    input  logic                                    s_axis_tready,
    input  logic [crc16lpfr_pkg::BYTE_W-1:0]        s_axis_tdata,
    input  logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    input  logic [crc16lpfr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic [1:0]                              m_axis_tuser
);
    import crc16lpfr_pkg::*;

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result word changed");

    // Only payload words carry a data byte.
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != KIND_PAYLOAD) |-> m_axis_tdata[7:0] == 8'h00)
        else $error("data byte set on a non-payload word");

    // A length error reports a short count and no identifier or CRC flag.
    a_len_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_LEN_ERR) |->
            (m_axis_tdata[32:17] < MIN_FRAME_LEN) && (m_axis_tdata[16:8] == 9'd0))
        else $error("malformed length error word");

    // Payload and completion words belong to frames of legal length.
    a_len_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && ((m_axis_tuser == KIND_PAYLOAD) || (m_axis_tuser == KIND_FRAME_DONE))
            |-> m_axis_tdata[32:17] >= MIN_FRAME_LEN)
        else $error("frame word with a short length");

    // The input is never refused while the output side is free.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output register");

endmodule

bind crc16_length_prefixed_frame_receiver_core crc16lpfr_checker u_crc16lpfr_checker (.*);
